// ===== sv/crc32_pkg.sv =====
// ----------------------------------------------------------------------------
// crc32_pkg
// Shared types and constants for the configurable CRC-32 engine.
// ----------------------------------------------------------------------------
package crc32_pkg;

  localparam int unsigned CrcW    = 32;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 3;

  // Configuration register map
  typedef enum logic [CfgIdxW-1:0] {
    CFG_POLYNOMIAL    = 3'd0,
    CFG_INITIAL_VALUE = 3'd1,
    CFG_FINAL_XOR     = 3'd2,
    CFG_REFLECTED     = 3'd3
  } cfg_idx_e;

  // Item opcodes
  typedef enum logic {
    OP_DATA    = 1'b0,
    OP_RESTART = 1'b1
  } op_e;

  // Reset configuration: standard reflected CRC-32
  localparam logic [CrcW-1:0] RstPolynomial = 32'h04C1_1DB7;
  localparam logic [CrcW-1:0] RstInitValue  = 32'hFFFF_FFFF;
  localparam logic [CrcW-1:0] RstFinalXor   = 32'hFFFF_FFFF;
  localparam logic            RstReflected  = 1'b1;

endpackage

// ===== sv/configurable_crc32_engine_unit.sv =====
// ----------------------------------------------------------------------------
// configurable_crc32_engine_unit
// Byte-wise CRC-32 with programmable polynomial, seed, final XOR and
// reflection.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o, opcode_i, data_byte_i): one item
//   per handshake. OP_DATA folds data_byte_i into the running CRC, OP_RESTART
//   reloads the register with the seed. Each item yields exactly one result.
//   Output channel (out_valid_o / out_stall_i, crc_value_o): the running CRC
//   XOR the final value, after the item has been applied.
//   Config channel (cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i):
//   writes polynomial, seed, final XOR or reflect flag; a write to a known
//   register also reloads the CRC register. Indexes above the map are
//   dropped. Write only while no item is in flight.
//   Path: an accepted item is captured in the input register, then its result
//   in the result register, which drives crc_value_o. Throughput is one item
//   per cycle while out_stall_i is low: the eight-step XOR division sits in
//   the single stage between the input register and the result register.
//   Reset loads the reflected CRC-32 configuration (0x04C11DB7, seed and
//   final XOR all ones) and empties both stages.
//   When out_stall_i holds a result, the input register still takes one
//   more item; only with both stages full does in_stall_o rise.
// ----------------------------------------------------------------------------
module configurable_crc32_engine_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [crc32_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [crc32_pkg::CrcW-1:0]         cfg_data_i,
  // input item channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               opcode_i,
  input  logic [crc32_pkg::ByteW-1:0]        data_byte_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [crc32_pkg::CrcW-1:0]         crc_value_o
);

  localparam int unsigned CrcW  = crc32_pkg::CrcW;
  localparam int unsigned ByteW = crc32_pkg::ByteW;

  // Bit reversal is pure wiring
  function automatic logic [CrcW-1:0] rev32(input logic [CrcW-1:0] v);
    logic [CrcW-1:0] r;
    for (int k = 0; k < CrcW; k++) begin
      r[k] = v[CrcW-1-k];
    end
    return r;
  endfunction

  // Eight shift/XOR steps, one per data bit
  function automatic logic [CrcW-1:0] fold_byte(input logic [CrcW-1:0]  crc,
                                                input logic [ByteW-1:0] b,
                                                input logic [CrcW-1:0]  poly,
                                                input logic             refl);
    logic [CrcW-1:0] r;
    logic            msb_out;
    if (refl) begin
      r = crc ^ {{(CrcW-ByteW){1'b0}}, b};
      for (int k = 0; k < ByteW; k++) begin
        msb_out = r[0];
        r       = r >> 1;
        if (msb_out) r = r ^ poly;
      end
    end else begin
      r = crc ^ {b, {(CrcW-ByteW){1'b0}}};
      for (int k = 0; k < ByteW; k++) begin
        msb_out = r[CrcW-1];
        r       = r << 1;
        if (msb_out) r = r ^ poly;
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers (raw, as written)
  // --------------------------------------------------------------------------
  logic [CrcW-1:0] poly_q, poly_d;
  logic [CrcW-1:0] init_q, init_d;
  logic [CrcW-1:0] fxor_q, fxor_d;
  logic            refl_q, refl_d;
  logic            cfg_we;
  logic            cfg_hit;

  // The user must write config only while idle (input register empty); the block does not enforce it.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_comb begin
    poly_d  = poly_q;
    init_d  = init_q;
    fxor_d  = fxor_q;
    refl_d  = refl_q;
    cfg_hit = 1'b0;
    if (cfg_we) begin
      case (crc32_pkg::cfg_idx_e'(cfg_index_i))
        crc32_pkg::CFG_POLYNOMIAL: begin
          poly_d  = cfg_data_i;
          cfg_hit = 1'b1;
        end
        crc32_pkg::CFG_INITIAL_VALUE: begin
          init_d  = cfg_data_i;
          cfg_hit = 1'b1;
        end
        crc32_pkg::CFG_FINAL_XOR: begin
          fxor_d  = cfg_data_i;
          cfg_hit = 1'b1;
        end
        crc32_pkg::CFG_REFLECTED: begin
          refl_d  = cfg_data_i[0];
          cfg_hit = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= crc32_pkg::RstPolynomial;
      init_q <= crc32_pkg::RstInitValue;
      fxor_q <= crc32_pkg::RstFinalXor;
      refl_q <= crc32_pkg::RstReflected;
    end else begin
      poly_q <= poly_d;
      init_q <= init_d;
      fxor_q <= fxor_d;
      refl_q <= refl_d;
    end
  end

  // Effective values: reversed in reflected mode
  logic [CrcW-1:0] eff_poly, eff_init, eff_fxor, eff_init_next;

  assign eff_poly      = refl_q ? rev32(poly_q) : poly_q;
  assign eff_init      = refl_q ? rev32(init_q) : init_q;
  assign eff_fxor      = refl_q ? rev32(fxor_q) : fxor_q;
  assign eff_init_next = refl_d ? rev32(init_d) : init_d;

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic             s1_valid_q, s1_valid_d;
  logic             s1_op_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_adv;
  logic             in_acc;
  logic             out_free;

  assign out_free   = ~out_valid_o | ~out_stall_i;
  assign s1_adv     = s1_valid_q & out_free;
  assign in_stall_o = s1_valid_q & ~out_free;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign s1_valid_d = in_acc | (s1_valid_q & ~s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q   <= opcode_i;
      s1_byte_q <= data_byte_i;
    end
  end

  // --------------------------------------------------------------------------
  // CRC register and result register
  // --------------------------------------------------------------------------
  logic [CrcW-1:0] crc_q, crc_d;
  logic [CrcW-1:0] crc_item;
  logic            out_valid_q, out_valid_d;
  logic [CrcW-1:0] out_crc_q;

  always_comb begin
    if (crc32_pkg::op_e'(s1_op_q) == crc32_pkg::OP_RESTART) begin
      crc_item = eff_init;
    end else begin
      crc_item = fold_byte(crc_q, s1_byte_q, eff_poly, refl_q);
    end
  end

  always_comb begin
    crc_d = crc_q;
    if (cfg_hit) begin
      crc_d = eff_init_next;
    end else if (s1_adv) begin
      crc_d = crc_item;
    end
  end

  assign out_valid_d = s1_adv | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= crc32_pkg::RstInitValue;
      out_valid_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_crc_q <= crc_item ^ eff_fxor;
    end
  end

  assign out_valid_o = out_valid_q;
  assign crc_value_o = out_crc_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A restart item reports seed XOR final value
  a_restart_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_op_q == crc32_pkg::OP_RESTART && !cfg_hit
      |=> crc_value_o == $past(eff_init ^ eff_fxor))
    else $error("restart result mismatch");

  // Result register tracks the CRC register after each item
  a_out_tracks_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && !cfg_hit |=> crc_value_o == (crc_q ^ $past(eff_fxor)))
    else $error("result not CRC xor final value");

  // Stall only with both stages holding items
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_o && out_stall_i)
    else $error("input stalled with room available");

  // An item leaving the input register always produces a result
  a_adv_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_o)
    else $error("item advanced without a result");

  // A known config write reloads the CRC register with the new seed
  a_cfg_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> crc_q == (refl_q ? rev32(init_q) : init_q))
    else $error("config write did not reload CRC register");

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the configurable CRC-32 engine. A behavioral
// CRC predictor tracks polynomial, seed, final XOR, reflection and the
// running register. Every accepted item queues one expected CRC, and each
// result leaving the block is compared against the head of that queue.
// Directed tests cover reset defaults, config extremes and reload behavior.
// Random phases then vary the configuration and the item stream, with
// random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CrcW    = crc32_pkg::CrcW;
  localparam int unsigned ByteW   = crc32_pkg::ByteW;
  localparam int unsigned CfgIdxW = crc32_pkg::CfgIdxW;

  localparam int unsigned IdlePct      = 24;
  localparam int unsigned WatchdogMax  = 5000;
  localparam int unsigned RandPhases   = 8;
  localparam int unsigned PhaseItems   = 200;
  localparam int unsigned DrainCycles  = 4;
  // first index past the register map; writes there must be dropped
  localparam logic [CfgIdxW-1:0] CfgIdxUnmapped =
    CfgIdxW'(crc32_pkg::CFG_REFLECTED) + 1'b1;
  localparam logic [CfgIdxW-1:0] CfgIdxTop      = '1;

  logic clk;
  logic rst_ni;

  logic               cfg_valid;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CrcW-1:0]    cfg_data;

  logic               in_valid;
  logic               in_stall_o;
  logic               opcode;
  logic [ByteW-1:0]   data_byte;

  logic               out_valid_o;
  logic               out_stall;
  logic [CrcW-1:0]    crc_value_o;

  // when set, neither side inserts idle cycles (back-to-back stretch)
  bit no_idle;
  int error_count;

  configurable_crc32_engine_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode),
    .data_byte_i (data_byte),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .crc_value_o (crc_value_o)
  );

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // CRC predictor: programmed registers plus the running CRC
  // --------------------------------------------------------------------------
  logic [CrcW-1:0] poly_reg;
  logic [CrcW-1:0] seed_reg;
  logic [CrcW-1:0] xorout_reg;
  logic            reflect_reg;
  logic [CrcW-1:0] running_crc;

  logic [CrcW-1:0] expected_crc_q[$];

  function automatic logic [CrcW-1:0] reverse_bits(input logic [CrcW-1:0] v);
    logic [CrcW-1:0] r;
    for (int k = 0; k < CrcW; k++) r[k] = v[CrcW-1-k];
    return r;
  endfunction

  // register value as the datapath uses it (bit-reversed in reflected mode)
  function automatic logic [CrcW-1:0] as_used(input logic [CrcW-1:0] v);
    return reflect_reg ? reverse_bits(v) : v;
  endfunction

  function automatic logic [CrcW-1:0] crc_fold_byte(input logic [CrcW-1:0] r,
                                                    input logic [ByteW-1:0] b);
    logic [CrcW-1:0] p;
    logic            carry;
    p = as_used(poly_reg);
    if (reflect_reg) begin
      r ^= {24'd0, b};
      for (int k = 0; k < 8; k++) begin
        carry = r[0];
        r     = r >> 1;
        if (carry) r ^= p;
      end
    end else begin
      r ^= {b, 24'd0};
      for (int k = 0; k < 8; k++) begin
        carry = r[CrcW-1];
        r     = r << 1;
        if (carry) r ^= p;
      end
    end
    return r;
  endfunction

  function automatic void crc_model_reset();
    poly_reg    = crc32_pkg::RstPolynomial;
    seed_reg    = crc32_pkg::RstInitValue;
    xorout_reg  = crc32_pkg::RstFinalXor;
    reflect_reg = crc32_pkg::RstReflected;
    running_crc = as_used(seed_reg);
  endfunction

  // any mapped write reloads the running CRC; unmapped ones change nothing
  function automatic void crc_model_write(input logic [CfgIdxW-1:0] idx,
                                          input logic [CrcW-1:0] val);
    case (idx)
      crc32_pkg::CFG_POLYNOMIAL:    poly_reg    = val;
      crc32_pkg::CFG_INITIAL_VALUE: seed_reg    = val;
      crc32_pkg::CFG_FINAL_XOR:     xorout_reg  = val;
      crc32_pkg::CFG_REFLECTED:     reflect_reg = val[0];
      default:                      return;
    endcase
    running_crc = as_used(seed_reg);
  endfunction

  function automatic logic [CrcW-1:0] crc_model_item(input crc32_pkg::op_e op,
                                                     input logic [ByteW-1:0] b);
    if (op == crc32_pkg::OP_RESTART) running_crc = as_used(seed_reg);
    else                             running_crc = crc_fold_byte(running_crc, b);
    return running_crc ^ as_used(xorout_reg);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stall plus in-order comparison
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < IdlePct);
  end

  always @(posedge clk) begin
    logic [CrcW-1:0] exp_crc;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_crc_q.size() == 0) begin
        $error("crc_value: no item pending, got %h", crc_value_o);
        error_count++;
      end else begin
        exp_crc = expected_crc_q.pop_front();
        if (crc_value_o !== exp_crc) begin
          $error("crc_value: expected %h, got %h", exp_crc, crc_value_o);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: cycles without any handshake on any channel
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    int quiet_cycles;
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogMax) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Valid is left high after acceptance; the next call either drops it for
  // an idle gap or replaces the payload, so valid only moves once per step.
  task automatic send_item(input crc32_pkg::op_e op, input logic [ByteW-1:0] b);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    data_byte <= b;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    expected_crc_q.push_back(crc_model_item(op, b));
  endtask

  // Stop feeding items and let every outstanding result leave the block.
  // Each item yields exactly one result, so an empty queue means idle.
  task automatic drain_items();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_crc_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CrcW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    crc_model_write(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_data_bytes(input int n);
    for (int i = 0; i < n; i++) send_item(crc32_pkg::OP_DATA, ByteW'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset configuration is standard reflected CRC-32: first item sees the
  // reset seed, then byte extremes, a restart and the "123456789" check run.
  task automatic test_reset_config();
    send_item(crc32_pkg::OP_DATA, 8'h00);
    send_item(crc32_pkg::OP_DATA, 8'hFF);
    send_item(crc32_pkg::OP_DATA, 8'h80);
    send_item(crc32_pkg::OP_RESTART, 8'hA5);
    for (int c = 8'h31; c <= 8'h39; c++) send_item(crc32_pkg::OP_DATA, ByteW'(c));
  endtask

  // Every register written, including extremes, in both bit orders.
  task automatic test_config_extremes();
    drain_items();
    write_cfg(crc32_pkg::CFG_REFLECTED, 32'd0);
    write_cfg(crc32_pkg::CFG_FINAL_XOR, 32'd0);
    send_item(crc32_pkg::OP_DATA, 8'h01);
    send_item(crc32_pkg::OP_DATA, 8'hFE);
    drain_items();
    write_cfg(crc32_pkg::CFG_POLYNOMIAL, 32'hFFFF_FFFF);
    write_cfg(crc32_pkg::CFG_INITIAL_VALUE, 32'd0);
    send_item(crc32_pkg::OP_DATA, 8'hFF);
    send_item(crc32_pkg::OP_RESTART, 8'h00);
    drain_items();
    write_cfg(crc32_pkg::CFG_POLYNOMIAL, 32'd0);
    write_cfg(crc32_pkg::CFG_REFLECTED, 32'hFFFF_FFFF);
    write_cfg(crc32_pkg::CFG_FINAL_XOR, 32'hFFFF_FFFF);
    send_item(crc32_pkg::OP_DATA, 8'h5A);
    send_item(crc32_pkg::OP_DATA, 8'hC3);
  endtask

  // A mapped write reloads the running CRC even with an unchanged value;
  // writes past the map must leave both config and running CRC alone.
  task automatic test_reload_and_unmapped();
    drain_items();
    write_cfg(crc32_pkg::CFG_POLYNOMIAL, crc32_pkg::RstPolynomial);
    send_item(crc32_pkg::OP_DATA, 8'h42);
    drain_items();
    write_cfg(crc32_pkg::CFG_INITIAL_VALUE, 32'hDEAD_BEEF);
    send_item(crc32_pkg::OP_DATA, 8'h17);
    drain_items();
    write_cfg(CfgIdxUnmapped, 32'hFFFF_FFFF);
    write_cfg(CfgIdxTop, 32'd0);
    send_item(crc32_pkg::OP_DATA, 8'h99);
  endtask

  function automatic logic [CrcW-1:0] pick_word(input logic [CrcW-1:0] typical);
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return typical;
      default: return $urandom;
    endcase
  endfunction

  // Random phases: new settings between phases, then message-like streams
  // (restart followed by a run of bytes) with the odd stray restart.
  task automatic test_random_streams();
    int sent;
    int run_len;
    for (int ph = 0; ph < RandPhases; ph++) begin
      drain_items();
      // one phase runs back to back on both channels
      no_idle = (ph == 3);
      if ($urandom_range(99) < 60)
        write_cfg(crc32_pkg::CFG_POLYNOMIAL, pick_word(crc32_pkg::RstPolynomial));
      if ($urandom_range(99) < 60)
        write_cfg(crc32_pkg::CFG_INITIAL_VALUE, pick_word(crc32_pkg::RstInitValue));
      if ($urandom_range(99) < 60)
        write_cfg(crc32_pkg::CFG_FINAL_XOR, pick_word(crc32_pkg::RstFinalXor));
      if ($urandom_range(99) < 60) write_cfg(crc32_pkg::CFG_REFLECTED, $urandom);
      if ($urandom_range(99) < 25)
        write_cfg(CfgIdxW'($urandom_range(CfgIdxUnmapped, CfgIdxTop)), $urandom);
      sent = 0;
      while (sent < PhaseItems) begin
        send_item(crc32_pkg::OP_RESTART, ByteW'($urandom));
        run_len = ($urandom_range(9) == 0) ? $urandom_range(40, 64) : $urandom_range(0, 16);
        for (int i = 0; i < run_len; i++) begin
          if ($urandom_range(99) < 3) send_item(crc32_pkg::OP_RESTART, ByteW'($urandom));
          else                        send_item(crc32_pkg::OP_DATA, ByteW'($urandom));
        end
        sent += run_len + 1;
      end
    end
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    error_count = 0;
    no_idle     = 1'b0;
    rst_ni    <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    opcode    <= crc32_pkg::OP_DATA;
    data_byte <= '0;
    crc_model_reset();
    repeat (7) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_reset_config();
    test_config_extremes();
    test_reload_and_unmapped();
    test_random_streams();

    drain_items();
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0 && expected_crc_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== configurable_crc32_engine_unit.f =====
sv/crc32_pkg.sv
sv/configurable_crc32_engine_unit.sv
dv/tb_top.sv
